@@ design/su2x_pkg.sv @@
// Shared types, constants and pointer helpers for the 2x-oversampled UART core.
// No dependencies; imported by su2x_skid and soft_uart_2x_oversample_core.
`timescale 1ns / 1ps
`default_nettype none

package su2x_pkg;

   localparam int RX_DEPTH = 32;
   localparam int TX_DEPTH = 32;
   localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
   localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // bit-timing phases, two ticks per bit
   localparam int PH_W = 5;
   localparam logic [PH_W-1:0] PH_IDLE      = 5'd0;
   localparam logic [PH_W-1:0] PH_START2    = 5'd1;
   localparam logic [PH_W-1:0] PH_DATA0     = 5'd2;
   localparam logic [PH_W-1:0] PH_DATA_LAST = 5'd16;
   localparam logic [PH_W-1:0] PH_STOP1     = 5'd18;
   localparam logic [PH_W-1:0] PH_STOP2     = 5'd19;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_FLUSH = 2'd3
   } action_type;

   typedef struct packed {
      logic       tx_line;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       line_irq;
      logic       tx_dropped;
      logic       sampler_active;
   } result_type;

   function automatic logic [RX_PTR_W-1:0] rx_inc(input logic [RX_PTR_W-1:0] p);
      return (p == RX_LAST) ? '0 : RX_PTR_W'(p + 1'b1);
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_inc(input logic [TX_PTR_W-1:0] p);
      return (p == TX_LAST) ? '0 : TX_PTR_W'(p + 1'b1);
   endfunction

endpackage

`default_nettype wire

@@ design/su2x_skid.sv @@
// Two-entry result buffer (output register plus skid stage) for the UART core.
// Depends on su2x_pkg for result_type.
`timescale 1ns / 1ps
`default_nettype none

module su2x_skid (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  su2x_pkg::result_type    in_data,
   output logic                    out_valid,
   input  wire                     out_ready,
   output su2x_pkg::result_type    out_data
);
   import su2x_pkg::*;

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       take;
   logic       push;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign take      = out_valid_ff && out_ready;
   assign push      = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !$past(skid_valid_ff)) |-> $past(out_valid_ff && !out_ready))
      else $error("skid filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> !skid_valid_ff)
      else $error("skid not drained after output taken");

endmodule

`default_nettype wire

@@ design/soft_uart_2x_oversample_core.sv @@
// Top level of the 8N1 UART core sampled at two ticks per bit, with RX/TX rings.
// Depends on su2x_pkg and su2x_skid.
//
// Usage: each req_ transaction carries one action: a sample tick (with the
// rx pin level), a TX byte write, an RX byte read or an RX flush. Every
// accepted transaction yields exactly one rsp_ transaction giving the tx pin
// level, the read result, the line interrupt, the drop flag and whether the
// sampler is running.
// Throughput: one transaction per cycle unless stalled; each result is
// registered in the output buffer. Both rings live in single-port-write
// synchronous RAMs; the entry at each read pointer is pre-read every cycle
// with write forwarding, so a read or a transmitted bit never waits.
// Stall: a two-entry output buffer lets one more request in while a response
// waits; with both entries full req_ready drops until rsp_ready returns.
// Reset: phases, pointers and flags clear, tx line goes high, sampler idle.
// Ring contents are not cleared; no clearing pass, ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module soft_uart_2x_oversample_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_action,
   input  wire         req_rx_line,
   input  wire  [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_tx_line,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic        rsp_line_irq,
   output logic        rsp_tx_dropped,
   output logic        rsp_sampler_active
);
   import su2x_pkg::*;

   logic [PH_W-1:0]     rx_phase_ff, rx_phase_in;
   logic [PH_W-1:0]     tx_phase_ff, tx_phase_in;
   logic [7:0]          rx_shift_ff, rx_shift_in;
   logic                active_ff, active_in;
   logic                line_out_ff, line_out_in;
   logic [RX_PTR_W-1:0] rx_head_ff, rx_head_in;
   logic [RX_PTR_W-1:0] rx_tail_ff, rx_tail_in;
   logic [TX_PTR_W-1:0] tx_head_ff, tx_head_in;
   logic [TX_PTR_W-1:0] tx_tail_ff, tx_tail_in;

   logic [7:0]          rx_mem [RX_DEPTH];
   logic [7:0]          tx_mem [TX_DEPTH];
   logic [7:0]          rx_q_ff;
   logic [7:0]          tx_q_ff;
   // marks TX slots that hold the CR appended after an LF
   logic [TX_DEPTH-1:0] tx_cr_ff;

   logic                accept;
   logic                run;
   logic                rx_we;
   logic                tx_we;
   logic                cr_set;
   logic                enq_req;
   logic [7:0]          enq_byte;
   logic [7:0]          echo_byte;
   logic [7:0]          tx_byte;
   logic [2:0]          tx_bit_idx;
   logic [TX_PTR_W-1:0] tx_nxt1;
   logic [TX_PTR_W-1:0] tx_nxt2;
   result_type          res;
   result_type          rsp_data;

   assign accept     = req_valid && req_ready;
   assign echo_byte  = (rx_shift_ff == CH_CR) ? CH_LF : rx_shift_ff;
   assign tx_byte    = tx_cr_ff[tx_tail_ff] ? CH_CR : tx_q_ff;
   assign tx_bit_idx = tx_phase_ff[3:1] - 3'd1;
   assign tx_nxt1    = tx_inc(tx_head_ff);
   assign tx_nxt2    = tx_inc(tx_nxt1);

   always_comb begin
      rx_phase_in = rx_phase_ff;
      tx_phase_in = tx_phase_ff;
      rx_shift_in = rx_shift_ff;
      active_in   = active_ff;
      line_out_in = line_out_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      run         = 1'b0;
      rx_we       = 1'b0;
      tx_we       = 1'b0;
      cr_set      = 1'b0;
      enq_req     = 1'b0;
      enq_byte    = req_data_byte;
      res         = '0;

      if (accept) begin
         case (req_action)
            ACT_TICK: begin
               run = active_ff || !req_rx_line;
            end
            ACT_WRITE: begin
               enq_req = 1'b1;
            end
            ACT_READ: begin
               if (rx_head_ff != rx_tail_ff) begin
                  res.read_byte  = rx_q_ff;
                  res.read_valid = 1'b1;
                  rx_tail_in     = rx_inc(rx_tail_ff);
               end
            end
            ACT_FLUSH: begin
               rx_head_in = '0;
               rx_tail_in = '0;
            end
            default: ;
         endcase
      end

      // receiver
      if (run) begin
         if (rx_phase_ff == PH_IDLE) begin
            if (!req_rx_line) begin
               rx_phase_in = PH_START2;
               rx_shift_in = '0;
            end
         end else if (rx_phase_ff == PH_START2) begin
            rx_phase_in = req_rx_line ? PH_IDLE : PH_DATA0;
         end else if (rx_phase_ff <= PH_DATA_LAST && !rx_phase_ff[0]) begin
            rx_shift_in = {req_rx_line, rx_shift_ff[7:1]};
            rx_phase_in = rx_phase_ff + 5'd1;
         end else if (rx_phase_ff == PH_STOP2) begin
            rx_shift_in  = echo_byte;
            rx_we        = 1'b1;
            rx_head_in   = rx_inc(rx_head_ff);
            enq_req      = 1'b1;
            enq_byte     = echo_byte;
            res.line_irq = (echo_byte == CH_LF);
            rx_phase_in  = PH_IDLE;
         end else begin
            rx_phase_in = rx_phase_ff + 5'd1;
         end
      end

      // TX enqueue; an LF takes a second slot for the CR
      if (enq_req) begin
         if (tx_nxt1 == tx_tail_ff) begin
            res.tx_dropped = 1'b1;
         end else begin
            tx_we      = 1'b1;
            tx_head_in = tx_nxt1;
            if (enq_byte == CH_LF) begin
               if (tx_nxt2 == tx_tail_ff) begin
                  res.tx_dropped = 1'b1;
               end else begin
                  cr_set     = 1'b1;
                  tx_head_in = tx_nxt2;
               end
            end
         end
      end

      // transmitter, sees the ring after this tick's echo
      if (run) begin
         if (tx_phase_ff == PH_IDLE) begin
            if (tx_head_in != tx_tail_ff) begin
               line_out_in = 1'b0;
               tx_phase_in = PH_START2;
            end
         end else if (tx_phase_ff >= PH_DATA0 && tx_phase_ff <= PH_DATA_LAST
                      && !tx_phase_ff[0]) begin
            line_out_in = tx_byte[tx_bit_idx];
            tx_phase_in = tx_phase_ff + 5'd1;
         end else if (tx_phase_ff == PH_STOP1) begin
            line_out_in = 1'b1;
            tx_phase_in = PH_STOP2;
         end else if (tx_phase_ff == PH_STOP2) begin
            tx_tail_in  = tx_inc(tx_tail_ff);
            tx_phase_in = PH_IDLE;
         end else begin
            tx_phase_in = tx_phase_ff + 5'd1;
         end
         active_in = !(rx_phase_in == PH_IDLE && tx_phase_in == PH_IDLE
                       && tx_head_in == tx_tail_in);
      end

      res.tx_line        = line_out_in;
      res.sampler_active = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff <= PH_IDLE;
         tx_phase_ff <= PH_IDLE;
         rx_shift_ff <= '0;
         active_ff   <= 1'b0;
         line_out_ff <= 1'b1;
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
      end else begin
         rx_phase_ff <= rx_phase_in;
         tx_phase_ff <= tx_phase_in;
         rx_shift_ff <= rx_shift_in;
         active_ff   <= active_in;
         line_out_ff <= line_out_in;
         rx_head_ff  <= rx_head_in;
         rx_tail_ff  <= rx_tail_in;
         tx_head_ff  <= tx_head_in;
         tx_tail_ff  <= tx_tail_in;
      end
   end

   // RX ring: write at head, pre-read entry at next tail with forwarding
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_head_ff] <= echo_byte;
      end
      if (rx_we && rx_head_ff == rx_tail_in) begin
         rx_q_ff <= echo_byte;
      end else begin
         rx_q_ff <= rx_mem[rx_tail_in];
      end
   end

   // TX ring: same scheme; CR slots live in tx_cr_ff instead of the RAM
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_head_ff]   <= enq_byte;
         tx_cr_ff[tx_head_ff] <= 1'b0;
      end
      if (cr_set) begin
         tx_cr_ff[tx_nxt1] <= 1'b1;
      end
      if (tx_we && tx_head_ff == tx_tail_in) begin
         tx_q_ff <= enq_byte;
      end else begin
         tx_q_ff <= tx_mem[tx_tail_in];
      end
   end

   su2x_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (res),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_tx_line        = rsp_data.tx_line;
   assign rsp_read_byte      = rsp_data.read_byte;
   assign rsp_read_valid     = rsp_data.read_valid;
   assign rsp_line_irq       = rsp_data.line_irq;
   assign rsp_tx_dropped     = rsp_data.tx_dropped;
   assign rsp_sampler_active = rsp_data.sampler_active;

   a_idle_phases: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (rx_phase_ff == PH_IDLE && tx_phase_ff == PH_IDLE))
      else $error("sampler idle with a machine mid-frame");

   a_line_low_in_frame: assert property (@(posedge clock) disable iff (reset)
      !line_out_ff |-> (tx_phase_ff != PH_IDLE))
      else $error("tx line low outside a frame");

   a_rx_phase_range: assert property (@(posedge clock) disable iff (reset)
      rx_phase_ff <= PH_STOP2)
      else $error("rx phase out of range");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for soft_uart_2x_oversample_core: drives actions and serial frames,
// predicts each response with a cycle-free UART/ring model and compares field by field.
// Depends on su2x_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import su2x_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int DRAIN_CYCLES = 10;

   localparam result_type QUIET = '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};

   typedef struct packed {
      action_type act;
      logic       rx;
      logic [7:0] data;
      logic       typed;   // want holds a hand-written expectation
      result_type want;
   } stim_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_TICK;
   logic        req_rx_line = 1'b1;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_line;
   logic [7:0]  rsp_read_byte;
   logic        rsp_read_valid;
   logic        rsp_line_irq;
   logic        rsp_tx_dropped;
   logic        rsp_sampler_active;

   // travel with the payload so the monitor knows a row's typed expectation
   logic        req_typed = 1'b0;
   result_type  req_want = QUIET;

   soft_uart_2x_oversample_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_rx_line        (req_rx_line),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tx_line        (rsp_tx_line),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_line_irq       (rsp_line_irq),
      .rsp_tx_dropped     (rsp_tx_dropped),
      .rsp_sampler_active (rsp_sampler_active)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor state
   logic [PH_W-1:0]     rx_ph, tx_ph;
   logic [7:0]          rx_sh;
   logic                awake;
   logic                tx_pin;
   logic [7:0]          rx_mem [RX_DEPTH];
   logic [7:0]          tx_mem [TX_DEPTH];
   logic [RX_PTR_W-1:0] rx_wr, rx_rd;
   logic [TX_PTR_W-1:0] tx_wr, tx_rd;

   result_type          uart_results_due [$];
   int unsigned         mismatch_count = 0;
   int unsigned         rsp_count = 0;
   int unsigned         item_count = 0;
   int unsigned         cycle_count = 0;
   logic                calm = 1'b0;
   int unsigned         stall_left = 0;

   initial begin
      rx_ph  = PH_IDLE;
      tx_ph  = PH_IDLE;
      rx_sh  = 8'h00;
      awake  = 1'b0;
      tx_pin = 1'b1;
      rx_wr  = '0;
      rx_rd  = '0;
      tx_wr  = '0;
      tx_rd  = '0;
      for (int i = 0; i < RX_DEPTH; i++) rx_mem[i] = 8'h00;
      for (int i = 0; i < TX_DEPTH; i++) tx_mem[i] = 8'h00;
   end

   // returns 1 when the TX ring is full and the byte is lost
   function automatic logic tx_push(input logic [7:0] b);
      logic [TX_PTR_W-1:0] nxt;
      nxt = TX_PTR_W'((tx_wr + 1) % TX_DEPTH);
      if (nxt == tx_rd) return 1'b1;
      tx_mem[tx_wr] = b;
      tx_wr = nxt;
      return 1'b0;
   endfunction

   // an LF is followed by a CR unless the LF itself was lost
   function automatic logic tx_queue_byte(input logic [7:0] b);
      if (tx_push(b)) return 1'b1;
      if (b == CH_LF) return tx_push(CH_CR);
      return 1'b0;
   endfunction

   task automatic step_uart(input action_type act, input logic rx, input logic [7:0] data,
                            output result_type r);
      logic [7:0] b;
      r = '0;
      case (act)
         ACT_TICK: begin
            if (!awake && !rx) awake = 1'b1;
            if (awake) begin
               // receiver
               if (rx_ph == PH_IDLE) begin
                  if (!rx) begin
                     rx_ph = PH_START2;
                     rx_sh = 8'h00;
                  end
               end else if (rx_ph == PH_START2) begin
                  rx_ph = rx ? PH_IDLE : PH_DATA0;
               end else if (rx_ph <= PH_DATA_LAST && !rx_ph[0]) begin
                  rx_sh = {rx, rx_sh[7:1]};
                  rx_ph = rx_ph + 1'b1;
               end else if (rx_ph == PH_STOP2) begin
                  b = (rx_sh == CH_CR) ? CH_LF : rx_sh;
                  rx_sh = b;
                  rx_mem[rx_wr] = b;
                  rx_wr = RX_PTR_W'((rx_wr + 1) % RX_DEPTH);
                  if (tx_queue_byte(b)) r.tx_dropped = 1'b1;
                  if (b == CH_LF) r.line_irq = 1'b1;
                  rx_ph = PH_IDLE;
               end else begin
                  rx_ph = rx_ph + 1'b1;
               end
               // transmitter; the ring entry is shifted out in place
               if (tx_ph == PH_IDLE) begin
                  if (tx_wr != tx_rd) begin
                     tx_pin = 1'b0;
                     tx_ph  = PH_START2;
                  end
               end else if (tx_ph >= PH_DATA0 && tx_ph <= PH_DATA_LAST && !tx_ph[0]) begin
                  tx_pin = tx_mem[tx_rd][0];
                  tx_mem[tx_rd] = tx_mem[tx_rd] >> 1;
                  tx_ph = tx_ph + 1'b1;
               end else if (tx_ph == PH_STOP1) begin
                  tx_pin = 1'b1;
                  tx_ph  = tx_ph + 1'b1;
               end else if (tx_ph == PH_STOP2) begin
                  tx_rd = TX_PTR_W'((tx_rd + 1) % TX_DEPTH);
                  tx_ph = PH_IDLE;
               end else begin
                  tx_ph = tx_ph + 1'b1;
               end
               if (rx_ph == PH_IDLE && tx_ph == PH_IDLE && tx_wr == tx_rd) awake = 1'b0;
            end
         end
         ACT_WRITE: r.tx_dropped = tx_queue_byte(data);
         ACT_READ: begin
            if (rx_wr != rx_rd) begin
               r.read_byte  = rx_mem[rx_rd];
               r.read_valid = 1'b1;
               rx_rd = RX_PTR_W'((rx_rd + 1) % RX_DEPTH);
            end
         end
         default: begin
            rx_wr = '0;
            rx_rd = '0;
         end
      endcase
      r.tx_line        = tx_pin;
      r.sampler_active = awake;
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch on %s at response %0d: expected %0h, got %0h",
               what, rsp_count, want, got);
      mismatch_count++;
   endtask

   result_type got_rsp, want_rsp, calc_rsp;

   always @(posedge clock) begin
      if (!reset) begin
         // response first: it always belongs to an earlier request
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got_rsp = {rsp_tx_line, rsp_read_byte, rsp_read_valid, rsp_line_irq,
                       rsp_tx_dropped, rsp_sampler_active};
            if (uart_results_due.size() == 0) begin
               report_mismatch("response with none expected", 0, 32'(got_rsp));
            end else begin
               want_rsp = uart_results_due.pop_front();
               if (got_rsp.tx_line !== want_rsp.tx_line)
                  report_mismatch("tx_line", 32'(want_rsp.tx_line), 32'(got_rsp.tx_line));
               if (got_rsp.read_byte !== want_rsp.read_byte)
                  report_mismatch("read_byte", 32'(want_rsp.read_byte),
                                  32'(got_rsp.read_byte));
               if (got_rsp.read_valid !== want_rsp.read_valid)
                  report_mismatch("read_valid", 32'(want_rsp.read_valid),
                                  32'(got_rsp.read_valid));
               if (got_rsp.line_irq !== want_rsp.line_irq)
                  report_mismatch("line_irq", 32'(want_rsp.line_irq), 32'(got_rsp.line_irq));
               if (got_rsp.tx_dropped !== want_rsp.tx_dropped)
                  report_mismatch("tx_dropped", 32'(want_rsp.tx_dropped),
                                  32'(got_rsp.tx_dropped));
               if (got_rsp.sampler_active !== want_rsp.sampler_active)
                  report_mismatch("sampler_active", 32'(want_rsp.sampler_active),
                                  32'(got_rsp.sampler_active));
            end
            rsp_count++;
         end
         if (req_valid && req_ready === 1'b1) begin
            step_uart(action_type'(req_action), req_rx_line, req_data_byte, calc_rsp);
            uart_results_due.push_back(req_typed ? req_want : calc_rsp);
         end
      end
   end

   // ---------------------------------------------------------------- idling
   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 99) < 95) ? $urandom_range(0, 2)
                                                    : $urandom_range(15, 40);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", uart_results_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // CR and LF come often so the conversion and echo paths get exercised
   function automatic logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return CH_CR;
      if (r < 35) return CH_LF;
      if (r < 40) return 8'h00;
      if (r < 45) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------- stimulus
   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_row(input stim_row row);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= row.act;
      req_rx_line   <= row.rx;
      req_data_byte <= row.data;
      req_typed     <= row.typed;
      req_want      <= row.want;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      item_count++;
   endtask

   task automatic send_item(input action_type act, input logic rx, input logic [7:0] data);
      send_row(stim_row'{act, rx, data, 1'b0, QUIET});
   endtask

   task automatic send_side_action();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         send_item(ACT_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else if (r < 90)
         send_item(ACT_WRITE, 1'($urandom_range(0, 1)), pick_byte());
      else
         send_item(ACT_FLUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   // one 8N1 frame, two ticks per bit; ticks stop early when cut is below 20
   task automatic send_frame(input logic [7:0] b, input logic mixed, input int unsigned cut,
                             input logic bad_stop);
      logic rx;
      for (int k = 0; k < 20 && k < cut; k++) begin
         if (k < 2) rx = 1'b0;
         else if (k < 18) rx = b[(k - 2) / 2];
         else rx = ~bad_stop;
         send_item(ACT_TICK, rx, 8'($urandom_range(0, 255)));
         if (mixed && $urandom_range(0, 99) < 10) send_side_action();
      end
   endtask

   stim_row directed_rows [0:20] = '{
      '{ACT_READ,  1'b1, 8'h00, 1'b1, QUIET},   // empty RX ring reads 0
      '{ACT_TICK,  1'b1, 8'hA5, 1'b1, QUIET},   // idle tick with line high ignored
      '{ACT_FLUSH, 1'b0, 8'hFF, 1'b1, QUIET},
      '{ACT_WRITE, 1'b1, 8'hFF, 1'b1, QUIET},
      '{ACT_WRITE, 1'b0, 8'h00, 1'b1, QUIET},
      '{ACT_WRITE, 1'b1, CH_LF, 1'b1, QUIET},   // queues LF and CR
      '{ACT_TICK,  1'b1, 8'h00, 1'b1, QUIET},   // still asleep with TX pending
      '{ACT_READ,  1'b0, 8'hFF, 1'b1, QUIET},
      '{ACT_TICK,  1'b0, 8'h00, 1'b0, QUIET},   // wakes, start of frame
      '{ACT_TICK,  1'b1, 8'h00, 1'b0, QUIET},   // false start
      '{ACT_TICK,  1'b0, 8'h00, 1'b0, QUIET},
      '{ACT_TICK,  1'b0, 8'h00, 1'b0, QUIET},
      '{ACT_TICK,  1'b1, 8'h00, 1'b0, QUIET},
      '{ACT_TICK,  1'b1, 8'h00, 1'b0, QUIET},
      '{ACT_FLUSH, 1'b1, 8'h00, 1'b0, QUIET},   // receiver phase survives a flush
      '{ACT_TICK,  1'b0, 8'h00, 1'b0, QUIET},
      '{ACT_TICK,  1'b0, 8'h00, 1'b0, QUIET},
      '{ACT_WRITE, 1'b0, CH_CR, 1'b0, QUIET},
      '{ACT_READ,  1'b1, 8'h00, 1'b0, QUIET},
      '{ACT_TICK,  1'b1, 8'h00, 1'b0, QUIET},
      '{ACT_TICK,  1'b1, 8'h00, 1'b0, QUIET}
   };

   initial begin
      int unsigned pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);
      item_count = 0;

      // RX overrun: more frames than the ring holds, no reads
      for (int f = 0; f < 34; f++) begin
         send_frame(pick_byte(), 1'b0, 20, 1'b0);
         if ($urandom_range(0, 3) == 0)
            send_item(ACT_TICK, 1'b1, 8'($urandom_range(0, 255)));
      end
      // fill the TX ring, then let an echo hit the full ring
      for (int w = 0; w < 36; w++) send_item(ACT_WRITE, 1'($urandom_range(0, 1)), pick_byte());
      send_frame(CH_LF, 1'b0, 20, 1'b0);

      while (item_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_frame(pick_byte(), 1'b1, 20, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(ACT_TICK, 1'b1, 8'($urandom_range(0, 255)));
         end else if (pick < 67) begin
            repeat ($urandom_range(1, 8)) send_item(ACT_READ, 1'($urandom_range(0, 1)),
                                                    8'($urandom_range(0, 255)));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 40)) send_item(ACT_WRITE, 1'($urandom_range(0, 1)),
                                                     pick_byte());
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 30)) begin
               if ($urandom_range(0, 9) == 0) send_side_action();
               else send_item(ACT_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end else if (pick < 95) begin
            // truncated frame or a stop bit held low
            send_frame(pick_byte(), 1'b1, $urandom_range(1, 20), 1'($urandom_range(0, 1)));
         end else begin
            send_item(ACT_FLUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end

      req_valid <= 1'b0;
      while (uart_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
